>>> sv/trfc_pkg.sv
package trfc_pkg;

    localparam int unsigned HOUR_W     = 5;
    localparam int unsigned MINUTE_W   = 6;
    localparam int unsigned SECOND_W   = 6;
    localparam int unsigned MINUTES_W  = 11;
    localparam int unsigned SHARE_W    = 8;
    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 11;

    localparam int unsigned ELAPSED_W  = 18;
    localparam int unsigned SCALED_W   = 26;
    localparam int unsigned DIVIDEND_W = 25;
    localparam int unsigned DIVISOR_W  = 17;
    localparam int unsigned STEP_W     = 5;
    localparam int unsigned SUM_W      = 10;
    localparam int unsigned PRODUCT_W  = 16;

    localparam logic [STEP_W-1:0] STEPS_SPAN  = STEP_W'(DIVIDEND_W);
    localparam logic [STEP_W-1:0] STEPS_SHARE = STEP_W'(PRODUCT_W);

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_RISE_MINUTES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_MINUTES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_SHARE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_SHARE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_SHARE   = 3'd4;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
        logic [STEP_W-1:0]     steps;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } t_div_rsp;

endpackage

>>> sv/trfc_div.sv
module trfc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  trfc_pkg::t_div_req i_req,
    output trfc_pkg::t_div_rsp o_rsp
);

    logic                            r_busy;
    logic                            r_done;
    logic [trfc_pkg::DIVIDEND_W-1:0] r_num;
    logic [trfc_pkg::DIVIDEND_W-1:0] r_quo;
    logic [trfc_pkg::DIVISOR_W-1:0]  r_div;
    logic [trfc_pkg::DIVISOR_W-1:0]  r_rem;
    logic [trfc_pkg::STEP_W-1:0]     r_cnt;

    logic [trfc_pkg::DIVISOR_W:0]    w_trial;
    logic [trfc_pkg::DIVISOR_W:0]    w_diff;
    logic                            w_ge;
    logic [trfc_pkg::DIVISOR_W-1:0]  n_rem;

    // Restoring division, one quotient bit per cycle, dividend consumed MSB first.
    assign w_trial = {r_rem, r_num[trfc_pkg::DIVIDEND_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};
    assign n_rem   = w_ge ? w_diff[trfc_pkg::DIVISOR_W-1:0]
                          : w_trial[trfc_pkg::DIVISOR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_num  <= i_req.dividend;
                r_div  <= i_req.divisor;
                r_rem  <= '0;
                r_quo  <= '0;
                r_cnt  <= i_req.steps;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[trfc_pkg::DIVIDEND_W-2:0], 1'b0};
                r_rem <= n_rem;
                r_quo <= {r_quo[trfc_pkg::DIVIDEND_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == trfc_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

>>> sv/timed_rgb_fade_controller_core.sv
// Timed RGB fade controller.
// The input channel carries items of cmd, hour, minute and second. A start item
// latches the start time and begins a fade-up, or a fade-down once a fade-up
// has finished; it gives no result. A tick item
// carries the current time and, while a fade runs, gives one result item with
// the three channel levels and the two activity flags. A tick with no fade
// running gives no result.
// All quotients go through one shared restoring divider, one bit per cycle.
// A fade-down tick uses at most one 25-step division, a fade-up tick at most
// one 25-step and three 16-step divisions. The block takes no new item while a
// tick is being worked on.
// The output register holds a result until it is taken; the next item is
// accepted meanwhile, and a later result waits in its final state until the
// output register is free.
// Configuration is written through a plain write port with no wait.
// Synchronous active-low reset clears the fade state, the start time, the
// configuration registers and the output valid flag.
module timed_rgb_fade_controller_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [trfc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [trfc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_cmd,
    input  logic [trfc_pkg::HOUR_W-1:0]     i_hour,
    input  logic [trfc_pkg::MINUTE_W-1:0]   i_minute,
    input  logic [trfc_pkg::SECOND_W-1:0]   i_second,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [trfc_pkg::LEVEL_W-1:0]    o_red_level,
    output logic [trfc_pkg::LEVEL_W-1:0]    o_green_level,
    output logic [trfc_pkg::LEVEL_W-1:0]    o_blue_level,
    output logic                            o_rising_active,
    output logic                            o_falling_active
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ELAP,
        S_DIV1,
        S_MIX,
        S_CDIV,
        S_DONE
    } t_state;

    t_state r_state;

    logic [trfc_pkg::MINUTES_W-1:0] r_rise_minutes;
    logic [trfc_pkg::MINUTES_W-1:0] r_fall_minutes;
    logic [trfc_pkg::SHARE_W-1:0]   r_red_share;
    logic [trfc_pkg::SHARE_W-1:0]   r_green_share;
    logic [trfc_pkg::SHARE_W-1:0]   r_blue_share;

    logic [trfc_pkg::HOUR_W-1:0]    r_start_hour;
    logic [trfc_pkg::MINUTE_W-1:0]  r_start_minute;
    logic [trfc_pkg::SECOND_W-1:0]  r_start_second;
    logic                           r_rise_running;
    logic                           r_fall_running;
    logic                           r_rise_done;

    logic [trfc_pkg::HOUR_W-1:0]    r_hour;
    logic [trfc_pkg::MINUTE_W-1:0]  r_minute;
    logic [trfc_pkg::SECOND_W-1:0]  r_second;
    logic                           r_up;
    logic                           r_neg;
    logic                           r_end;
    logic [trfc_pkg::LEVEL_W-1:0]   r_level;
    logic [1:0]                     r_ch;
    logic [trfc_pkg::LEVEL_W-1:0]   r_chan [3];

    logic                           r_out_valid;
    logic [trfc_pkg::LEVEL_W-1:0]   r_out_red;
    logic [trfc_pkg::LEVEL_W-1:0]   r_out_green;
    logic [trfc_pkg::LEVEL_W-1:0]   r_out_blue;
    logic                           r_out_rise;
    logic                           r_out_fall;

    trfc_pkg::t_div_req             r_div_req;
    trfc_pkg::t_div_rsp             w_div_rsp;

    logic signed [trfc_pkg::MINUTE_W:0]    w_dh;
    logic signed [trfc_pkg::MINUTE_W:0]    w_dm;
    logic signed [trfc_pkg::MINUTE_W:0]    w_ds;
    logic signed [trfc_pkg::ELAPSED_W-1:0] w_elapsed;
    logic signed [trfc_pkg::SCALED_W-1:0]  w_e_wide;
    logic signed [trfc_pkg::SCALED_W-1:0]  w_scaled;
    logic [trfc_pkg::SCALED_W-1:0]         w_scaled_abs;
    logic [trfc_pkg::MINUTES_W-1:0]        w_minutes;
    logic [trfc_pkg::DIVISOR_W-1:0]        w_span;
    logic [trfc_pkg::SUM_W-1:0]            w_sum;
    logic [trfc_pkg::SHARE_W-1:0]          w_share;
    logic [trfc_pkg::PRODUCT_W-1:0]        w_product;
    logic [trfc_pkg::DIVIDEND_W:0]         w_ceil;
    logic [trfc_pkg::DIVIDEND_W:0]         w_down_level;
    logic                                  w_out_free;
    logic                                  n_rise_running;
    logic                                  n_fall_running;
    logic                                  n_rise_done;

    trfc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_dh = $signed({2'b00, r_hour}) - $signed({2'b00, r_start_hour});
    assign w_dm = $signed({1'b0, r_minute}) - $signed({1'b0, r_start_minute});
    assign w_ds = $signed({1'b0, r_second}) - $signed({1'b0, r_start_second});

    assign w_elapsed = trfc_pkg::ELAPSED_W'(w_dh * $signed(18'sd3600))
                     + trfc_pkg::ELAPSED_W'(w_dm * $signed(18'sd60))
                     + trfc_pkg::ELAPSED_W'(w_ds);

    assign w_e_wide     = trfc_pkg::SCALED_W'(w_elapsed);
    assign w_scaled     = (w_e_wide <<< 8) - w_e_wide;
    assign w_scaled_abs = w_scaled[trfc_pkg::SCALED_W-1] ? trfc_pkg::SCALED_W'(-w_scaled)
                                                          : trfc_pkg::SCALED_W'(w_scaled);

    assign w_minutes = r_up ? r_rise_minutes : r_fall_minutes;
    assign w_span    = (trfc_pkg::DIVISOR_W'(w_minutes) << 6)
                     - (trfc_pkg::DIVISOR_W'(w_minutes) << 2);

    assign w_sum = trfc_pkg::SUM_W'(r_red_share) + trfc_pkg::SUM_W'(r_green_share)
                 + trfc_pkg::SUM_W'(r_blue_share);

    always_comb begin
        case (r_ch)
            2'd0:    w_share = r_red_share;
            2'd1:    w_share = r_green_share;
            default: w_share = r_blue_share;
        endcase
    end

    assign w_product    = trfc_pkg::PRODUCT_W'(r_level) * trfc_pkg::PRODUCT_W'(w_share);
    assign w_ceil       = {1'b0, w_div_rsp.quotient}
                        + (trfc_pkg::DIVIDEND_W+1)'(w_div_rsp.remainder != '0);
    assign w_down_level = (trfc_pkg::DIVIDEND_W+1)'(trfc_pkg::LEVEL_MAX) - w_ceil;
    assign w_out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_rise_running = r_rise_running;
        n_fall_running = r_fall_running;
        n_rise_done    = r_rise_done;
        if (r_end && r_up) begin
            n_rise_running = 1'b0;
            n_rise_done    = 1'b1;
        end else if (r_end) begin
            n_fall_running = 1'b0;
            n_rise_done    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_rise_minutes  <= '0;
            r_fall_minutes  <= '0;
            r_red_share     <= '0;
            r_green_share   <= '0;
            r_blue_share    <= '0;
            r_start_hour    <= '0;
            r_start_minute  <= '0;
            r_start_second  <= '0;
            r_rise_running  <= 1'b0;
            r_fall_running  <= 1'b0;
            r_rise_done     <= 1'b0;
            r_out_valid     <= 1'b0;
            r_div_req.start <= 1'b0;
        end else begin
            r_div_req.start <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    trfc_pkg::CFG_RISE_MINUTES: r_rise_minutes <= i_cfg_data;
                    trfc_pkg::CFG_FALL_MINUTES: r_fall_minutes <= i_cfg_data;
                    trfc_pkg::CFG_RED_SHARE:
                        r_red_share <= i_cfg_data[trfc_pkg::SHARE_W-1:0];
                    trfc_pkg::CFG_GREEN_SHARE:
                        r_green_share <= i_cfg_data[trfc_pkg::SHARE_W-1:0];
                    trfc_pkg::CFG_BLUE_SHARE:
                        r_blue_share <= i_cfg_data[trfc_pkg::SHARE_W-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_cmd == trfc_pkg::CMD_START) begin
                            r_start_hour   <= i_hour;
                            r_start_minute <= i_minute;
                            r_start_second <= i_second;
                            if (r_rise_done) begin
                                r_fall_running <= 1'b1;
                            end else begin
                                r_rise_running <= 1'b1;
                            end
                        end else if (r_rise_running || r_fall_running) begin
                            r_hour   <= i_hour;
                            r_minute <= i_minute;
                            r_second <= i_second;
                            r_up     <= r_rise_running;
                            r_state  <= S_ELAP;
                        end
                    end
                end
                S_ELAP: begin
                    r_neg <= w_elapsed[trfc_pkg::ELAPSED_W-1];
                    r_ch  <= 2'd0;
                    if (w_span == '0) begin
                        r_end   <= 1'b1;
                        r_level <= r_up ? trfc_pkg::LEVEL_MAX : '0;
                        r_state <= r_up ? S_MIX : S_DONE;
                    end else if (r_up && w_elapsed[trfc_pkg::ELAPSED_W-1]) begin
                        r_end   <= 1'b1;
                        r_level <= trfc_pkg::LEVEL_MAX;
                        r_state <= S_MIX;
                    end else begin
                        r_end              <= 1'b0;
                        r_div_req.start    <= 1'b1;
                        r_div_req.dividend <= w_scaled_abs[trfc_pkg::DIVIDEND_W-1:0];
                        r_div_req.divisor  <= w_span;
                        r_div_req.steps    <= trfc_pkg::STEPS_SPAN;
                        r_state            <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (w_div_rsp.done) begin
                        if (r_up) begin
                            if (w_div_rsp.quotient >= trfc_pkg::DIVIDEND_W'(trfc_pkg::LEVEL_MAX))
                            begin
                                r_end   <= 1'b1;
                                r_level <= trfc_pkg::LEVEL_MAX;
                            end else begin
                                r_level <= w_div_rsp.quotient[trfc_pkg::LEVEL_W-1:0];
                            end
                            r_state <= S_MIX;
                        end else begin
                            if (r_neg) begin
                                if (w_div_rsp.quotient == '0) begin
                                    r_level <= trfc_pkg::LEVEL_MAX;
                                end else begin
                                    r_end   <= 1'b1;
                                    r_level <= '0;
                                end
                            end else if (w_ceil >= (trfc_pkg::DIVIDEND_W+1)'(trfc_pkg::LEVEL_MAX))
                            begin
                                r_end   <= 1'b1;
                                r_level <= '0;
                            end else begin
                                r_level <= w_down_level[trfc_pkg::LEVEL_W-1:0];
                            end
                            r_state <= S_DONE;
                        end
                    end
                end
                S_MIX: begin
                    if (w_sum == '0) begin
                        r_chan[0] <= '0;
                        r_chan[1] <= '0;
                        r_chan[2] <= '0;
                        r_state   <= S_DONE;
                    end else begin
                        r_div_req.start    <= 1'b1;
                        r_div_req.dividend <= {w_product,
                            (trfc_pkg::DIVIDEND_W-trfc_pkg::PRODUCT_W)'(0)};
                        r_div_req.divisor  <= trfc_pkg::DIVISOR_W'(w_sum);
                        r_div_req.steps    <= trfc_pkg::STEPS_SHARE;
                        r_state            <= S_CDIV;
                    end
                end
                S_CDIV: begin
                    if (w_div_rsp.done) begin
                        r_chan[r_ch] <= w_div_rsp.quotient[trfc_pkg::LEVEL_W-1:0];
                        if (r_ch == 2'd2) begin
                            r_state <= S_DONE;
                        end else begin
                            r_ch    <= r_ch + 2'd1;
                            r_state <= S_MIX;
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_red      <= r_up ? r_chan[0] : r_level;
                        r_out_green    <= r_up ? r_chan[1] : r_level;
                        r_out_blue     <= r_up ? r_chan[2] : r_level;
                        r_out_rise     <= n_rise_running;
                        r_out_fall     <= n_fall_running;
                        r_rise_running <= n_rise_running;
                        r_fall_running <= n_fall_running;
                        r_rise_done    <= n_rise_done;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_red_level      = r_out_red;
    assign o_green_level    = r_out_green;
    assign o_blue_level     = r_out_blue;
    assign o_rising_active  = r_out_rise;
    assign o_falling_active = r_out_fall;

endmodule

>>> sv/trfc_checker.sv
module trfc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_we,
    input logic [trfc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [trfc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            i_cmd,
    input logic [trfc_pkg::HOUR_W-1:0]     i_hour,
    input logic [trfc_pkg::MINUTE_W-1:0]   i_minute,
    input logic [trfc_pkg::SECOND_W-1:0]   i_second,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [trfc_pkg::LEVEL_W-1:0]    o_red_level,
    input logic [trfc_pkg::LEVEL_W-1:0]    o_green_level,
    input logic [trfc_pkg::LEVEL_W-1:0]    o_blue_level,
    input logic                            o_rising_active,
    input logic                            o_falling_active
);

    // The output register is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result item valid after reset");

    // A stalled result item holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_red_level)
            && $stable(o_green_level) && $stable(o_blue_level)
            && $stable(o_rising_active) && $stable(o_falling_active))
        else $error("stalled result item changed");

    // A fade-up and a fade-down never run together.
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_rising_active && o_falling_active))
        else $error("both fades reported active");

    // A running fade-down drives all channels to the same level.
    a_fall_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_falling_active |->
            o_red_level == o_green_level && o_green_level == o_blue_level)
        else $error("fade-down channels differ");

endmodule

bind timed_rgb_fade_controller_core trfc_checker u_trfc_checker (.*);
